// File: hw/rtl/ptcl_pkg.sv
// ----------------------------------------------------------------------------
// ptcl_pkg
// Shared types and constants for the per-type request cooldown limiter:
// event mode codes, register indexes and stream field widths.
// ----------------------------------------------------------------------------
package ptcl_pkg;

    // event mode carried on the slave tuser
    typedef enum logic [2:0] {
        MODE_CHECK    = 3'd0,
        MODE_SENT     = 3'd1,
        MODE_BROWSE   = 3'd2,
        MODE_PACKET   = 3'd3,
        MODE_COMPLETE = 3'd4
    } t_mode;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_COOLDOWN   = 1'b0,
        CFG_GET_ALL_COOLDOWN = 1'b1
    } t_cfg_idx;

    // field widths
    localparam int MODE_W   = 3;
    localparam int REQ_W    = 4;
    localparam int CNT_W    = 16;
    localparam int TIME_W   = 32;
    localparam int S_DATA_W = 56;  // 53 bits of fields, zero filled to bytes
    localparam int M_DATA_W = 8;   // 2 bits of fields, zero filled to a byte

    // slave tdata bit positions
    localparam int S_REQ_LSB  = 0;
    localparam int S_CNT_LSB  = S_REQ_LSB + REQ_W;
    localparam int S_FLAG_BIT = S_CNT_LSB + CNT_W;
    localparam int S_TIME_LSB = S_FLAG_BIT + 1;

endpackage

// File: hw/rtl/per_type_request_cooldown_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_type_request_cooldown_limiter_unit
// Per-type request cooldown limiter with outstanding reply tracking.
// ----------------------------------------------------------------------------
// Each transfer on the slave side names a request type, the current tick
// count and an event mode; the block answers with may_send and
// may_send_get_all, judged from the state before the event, then applies the
// event to the per-type pending count and activity stamp table. One item is
// taken every clock cycle when the master side keeps up; each result passes
// through the input register, then the result register, and the
// read-modify-write of the per-type table sits between the two registers.
// A stamp of zero reads as never active. Configuration writes are accepted in
// every cycle and should only be made while the block is idle.
module per_type_request_cooldown_limiter_unit #(
    parameter int NUM_TYPES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata from bit 0: req_type[3:0], reply_count[19:4], get_all_flag[20],
    // time_now[52:21], zero fill[55:53]
    input  logic [ptcl_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: mode[2:0]
    input  logic [ptcl_pkg::MODE_W-1:0]   s_tuser,
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata from bit 0: may_send[0], may_send_get_all[1], zero fill[7:2]
    output logic [ptcl_pkg::M_DATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptcl_pkg::TIME_W-1:0]   i_cfg_data
);
    import ptcl_pkg::*;

    localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam logic [REQ_W:0] NUM_TYPES_C = (REQ_W+1)'(NUM_TYPES);

    // configuration registers
    logic [TIME_W-1:0] r_query_cd;
    logic [TIME_W-1:0] r_get_all_cd;

    // input register
    logic              r_in_valid;
    t_mode             r_mode;
    logic [REQ_W-1:0]  r_req;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_flag;
    logic [TIME_W-1:0] r_now;

    // per-type state table
    logic [CNT_W-1:0]  r_pend [NUM_TYPES];
    logic [TIME_W-1:0] r_last [NUM_TYPES];
    logic [TIME_W-1:0] r_ga_last;
    logic [CNT_W-1:0]  n_pend [NUM_TYPES];
    logic [TIME_W-1:0] n_last [NUM_TYPES];
    logic [TIME_W-1:0] n_ga_last;

    // result register
    logic r_out_valid;
    logic r_may;
    logic r_may_all;

    logic              w_advance;
    logic              w_fire;
    logic              w_type_ok;
    logic [TYPE_W-1:0] w_idx;
    logic [CNT_W-1:0]  w_pend;
    logic [TIME_W-1:0] w_last;
    logic [TIME_W-1:0] w_q_diff;
    logic [TIME_W-1:0] w_ga_diff;
    logic              w_q_cool;
    logic              w_ga_cool;
    logic              w_may;
    logic              w_may_all;

    // handshake: result register frees when empty or taken
    assign w_advance   = !r_out_valid || m_tready;
    assign w_fire      = r_in_valid && w_advance;
    assign s_tready    = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {{(M_DATA_W-2){1'b0}}, r_may_all, r_may};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_cd   <= '0;
            r_get_all_cd <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_QUERY_COOLDOWN:   r_query_cd   <= i_cfg_data;
                CFG_GET_ALL_COOLDOWN: r_get_all_cd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_mode <= t_mode'(s_tuser);
            r_req  <= s_tdata[S_REQ_LSB +: REQ_W];
            r_cnt  <= s_tdata[S_CNT_LSB +: CNT_W];
            r_flag <= s_tdata[S_FLAG_BIT];
            r_now  <= s_tdata[S_TIME_LSB +: TIME_W];
        end
    end

    // table read and cooldown tests
    assign w_type_ok = {1'b0, r_req} < NUM_TYPES_C;
    assign w_idx     = r_req[TYPE_W-1:0];
    assign w_pend    = r_pend[w_idx];
    assign w_last    = r_last[w_idx];
    assign w_q_diff  = r_now - w_last - r_query_cd;
    assign w_ga_diff = r_now - r_ga_last - r_get_all_cd;
    assign w_q_cool  = (w_last == '0) || !w_q_diff[TIME_W-1];
    assign w_ga_cool = (r_ga_last == '0) || !w_ga_diff[TIME_W-1];
    assign w_may     = w_type_ok && (w_pend == '0) && w_q_cool;
    assign w_may_all = w_may && w_ga_cool;

    // event update of the table
    always_comb begin
        n_pend    = r_pend;
        n_last    = r_last;
        n_ga_last = r_ga_last;
        if (w_fire) begin
            case (r_mode)
                MODE_SENT: begin
                    if (w_type_ok) begin
                        n_pend[w_idx] = (r_cnt == '0) ? CNT_W'(1) : r_cnt;
                        n_last[w_idx] = r_now;
                    end
                end
                MODE_BROWSE: begin
                    n_pend[0] = CNT_W'(1);
                    n_last[0] = r_now;
                    if (r_flag) begin
                        n_ga_last = r_now;
                    end
                end
                MODE_PACKET: begin
                    if (w_type_ok) begin
                        if (w_pend != '0) begin
                            n_pend[w_idx] = w_pend - CNT_W'(1);
                        end
                        n_last[w_idx] = r_now;
                    end
                end
                MODE_COMPLETE: begin
                    if (w_type_ok) begin
                        n_pend[w_idx] = '0;
                        n_last[w_idx] = r_now;
                    end
                end
                default: ;
            endcase
        end
    end

    // table registers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                r_pend[i] <= '0;
                r_last[i] <= '0;
            end
            r_ga_last <= '0;
        end else begin
            r_pend    <= n_pend;
            r_last    <= n_last;
            r_ga_last <= n_ga_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_may     <= w_may;
            r_may_all <= w_may_all;
        end
    end

endmodule

// File: hw/rtl/ptcl_checker.sv
// ----------------------------------------------------------------------------
// ptcl_checker
// Port-level checks for the per-type request cooldown limiter.
// ----------------------------------------------------------------------------
module ptcl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ptcl_pkg::M_DATA_W-1:0] m_tdata
);

    // no result is shown in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid straight after reset");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // get-all permission implies type permission
    a_get_all_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[0]))
        else $error("get-all allowed while type not allowed");

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind per_type_request_cooldown_limiter_unit ptcl_checker u_ptcl_checker (.*);

// File: dv/per_type_request_cooldown_limiter_unit_tb.sv
// ----------------------------------------------------------------------------
// per_type_request_cooldown_limiter_unit_tb
// Self-checking bench for the per-type request cooldown limiter: a scoreboard
// class mirrors the pending-count and activity-stamp table, predicts both
// verdicts for every accepted request and checks each result transfer in
// order, while random stalls hit both stream sides.
// ----------------------------------------------------------------------------
module per_type_request_cooldown_limiter_unit_tb;
    import ptcl_pkg::*;

    localparam int TYPES        = 8;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int END_SETTLE   = 8;
    localparam int PHASE_ITEMS  = 262;
    localparam int NUM_PHASES   = 7;
    localparam int MAX_REPORTS  = 10;

    // spare mode codes, decoded as check only
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic may_send;
        logic may_send_get_all;
    } t_verdict;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic [MODE_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [TIME_W-1:0]      i_cfg_data;

    // mirror of the limiter table and the verdicts still owed by the block
    class cooldown_scoreboard;
        logic [TIME_W-1:0] query_cd;
        logic [TIME_W-1:0] get_all_cd;
        logic [CNT_W-1:0]  pending[TYPES];
        logic [TIME_W-1:0] stamp[TYPES];
        logic [TIME_W-1:0] get_all_stamp;
        t_verdict          verdicts_due[$];
        int                errors;

        function new();
            query_cd      = '0;
            get_all_cd    = '0;
            get_all_stamp = '0;
            errors        = 0;
            for (int i = 0; i < TYPES; i++) begin
                pending[i] = '0;
                stamp[i]   = '0;
            end
        endfunction

        function void set_cooldown(t_cfg_idx idx, logic [TIME_W-1:0] val);
            if (idx == CFG_QUERY_COOLDOWN)
                query_cd = val;
            else
                get_all_cd = val;
        endfunction

        // a zero stamp means never active; otherwise the wrapped slack must be >= 0
        function bit cooled(logic [TIME_W-1:0] now, logic [TIME_W-1:0] last,
                            logic [TIME_W-1:0] cd);
            logic [TIME_W-1:0] slack;
            slack = now - last - cd;
            return (last == '0) || !slack[TIME_W-1];
        endfunction

        // judge from the old state, then apply the event
        function void note_request(logic [MODE_W-1:0] mode, logic [REQ_W-1:0] rtype,
                                   logic [CNT_W-1:0] cnt, logic flag,
                                   logic [TIME_W-1:0] now);
            t_verdict v;
            bit       known;
            int       t;
            known = rtype < TYPES;
            t     = known ? int'(rtype) : 0;
            v     = '0;
            if (known) begin
                v.may_send         = (pending[t] == '0) && cooled(now, stamp[t], query_cd);
                v.may_send_get_all = v.may_send && cooled(now, get_all_stamp, get_all_cd);
            end
            verdicts_due.push_back(v);
            case (mode)
                MODE_SENT: begin
                    if (known) begin
                        pending[t] = (cnt == '0) ? CNT_W'(1) : cnt;
                        stamp[t]   = now;
                    end
                end
                MODE_BROWSE: begin
                    pending[0] = CNT_W'(1);
                    stamp[0]   = now;
                    if (flag)
                        get_all_stamp = now;
                end
                MODE_PACKET: begin
                    if (known) begin
                        if (pending[t] != '0)
                            pending[t] = pending[t] - CNT_W'(1);
                        stamp[t] = now;
                    end
                end
                MODE_COMPLETE: begin
                    if (known) begin
                        pending[t] = '0;
                        stamp[t]   = now;
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string what, logic exp_bit, logic got_bit);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch on %s: expected %0b, got %0b", what, exp_bit, got_bit);
        endfunction

        function void check_verdict(logic [M_DATA_W-1:0] data);
            t_verdict exp_v;
            if (verdicts_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result transfer with no request waiting, data %0h", data);
                return;
            end
            exp_v = verdicts_due.pop_front();
            if (data[0] !== exp_v.may_send)
                report("may_send", exp_v.may_send, data[0]);
            if (data[1] !== exp_v.may_send_get_all)
                report("may_send_get_all", exp_v.may_send_get_all, data[1]);
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction
    endclass

    cooldown_scoreboard sb;
    int                 idle_cycles;
    bit                 run_live;

    per_type_request_cooldown_limiter_unit #(
        .NUM_TYPES (TYPES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // result side back-pressure
    initial begin
        int g;
        m_tready <= 1'b0;
        @(posedge i_clk);
        while (!run_live) @(posedge i_clk);
        forever begin
            g = pick_gap();
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (run_live && m_tvalid && m_tready)
            sb.check_verdict(m_tdata);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!run_live || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // write both cooldowns with valid held across the two transfers
    task automatic program_cooldowns(logic [TIME_W-1:0] q_cd, logic [TIME_W-1:0] g_cd);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_QUERY_COOLDOWN;
        i_cfg_data  <= q_cd;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_cooldown(CFG_QUERY_COOLDOWN, q_cd);
        i_cfg_index <= CFG_GET_ALL_COOLDOWN;
        i_cfg_data  <= g_cd;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_cooldown(CFG_GET_ALL_COOLDOWN, g_cd);
        i_cfg_valid <= 1'b0;
    endtask

    // one request transfer; valid stays high afterwards until the next gap
    task automatic send_request(logic [MODE_W-1:0] mode, logic [REQ_W-1:0] rtype,
                                logic [CNT_W-1:0] cnt, logic flag,
                                logic [TIME_W-1:0] now);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {3'b000, now, flag, cnt, rtype};
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(mode, rtype, cnt, flag, now);
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // hand-picked sequence over the corner cases, cooldowns 10 and 40
    task automatic run_directed();
        // never-stamped type, then a send stamped at time zero
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd0);
        send_request(MODE_SENT,     4'd0,  16'd0,     1'b0, 32'd0);
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd5);
        send_request(MODE_PACKET,   4'd0,  16'd0,     1'b0, 32'd0);
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd1);
        // packet with nothing pending still stamps
        send_request(MODE_PACKET,   4'd0,  16'd0,     1'b0, 32'd100);
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd109);
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd110);
        // browse ignores its type and always hits type 0
        send_request(MODE_BROWSE,   4'd9,  16'd7,     1'b1, 32'd200);
        send_request(MODE_CHECK,    4'd0,  16'd0,     1'b0, 32'd215);
        send_request(MODE_CHECK,    4'd3,  16'd0,     1'b0, 32'd239);
        send_request(MODE_CHECK,    4'd3,  16'd0,     1'b0, 32'd240);
        send_request(MODE_BROWSE,   4'd5,  16'd0,     1'b0, 32'd250);
        send_request(MODE_COMPLETE, 4'd0,  16'd0,     1'b0, 32'd260);
        // full reply count and completion near the top of the tick range
        send_request(MODE_SENT,     4'd7,  16'hFFFF,  1'b0, 32'd300);
        send_request(MODE_PACKET,   4'd7,  16'd0,     1'b0, 32'd400);
        send_request(MODE_CHECK,    4'd7,  16'd0,     1'b0, 32'd500);
        send_request(MODE_COMPLETE, 4'd7,  16'd0,     1'b0, 32'hFFFF_FFFF);
        send_request(MODE_CHECK,    4'd7,  16'd0,     1'b0, 32'd8);
        send_request(MODE_CHECK,    4'd7,  16'd0,     1'b0, 32'd9);
        // types out of range
        send_request(MODE_SENT,     4'd15, 16'd3,     1'b1, 32'd600);
        send_request(MODE_PACKET,   4'd8,  16'd0,     1'b0, 32'd610);
        send_request(MODE_COMPLETE, 4'd12, 16'd0,     1'b0, 32'd620);
        send_request(MODE_CHECK,    4'd15, 16'd0,     1'b0, 32'd630);
        // spare mode codes behave as check only
        for (int m = int'(MODE_SPARE_FIRST); m <= int'(MODE_SPARE_LAST); m++)
            send_request(MODE_W'(m), 4'd1, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    function automatic logic [MODE_W-1:0] MODE_LO_PICK();
        return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    endfunction

    // random requests around a running tick count
    task automatic run_phase(int count, logic [TIME_W-1:0] start_time);
        logic [TIME_W-1:0]  now;
        logic [MODE_W-1:0]  mode;
        logic [REQ_W-1:0]   rtype;
        logic [CNT_W-1:0]   cnt;
        int                 r;
        now = start_time;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                now = '0;
            else if (r < 5)
                now = $urandom();
            else
                now = now + TIME_W'($urandom_range(0, 24));

            r = $urandom_range(0, 99);
            if (r < 22)
                mode = MODE_CHECK;
            else if (r < 42)
                mode = MODE_SENT;
            else if (r < 50)
                mode = MODE_BROWSE;
            else if (r < 80)
                mode = MODE_PACKET;
            else if (r < 93)
                mode = MODE_COMPLETE;
            else
                mode = MODE_LO_PICK();

            if ($urandom_range(0, 99) < 88)
                rtype = REQ_W'($urandom_range(0, TYPES - 1));
            else
                rtype = REQ_W'($urandom_range(TYPES, 15));

            r = $urandom_range(0, 99);
            if (r < 72)
                cnt = CNT_W'($urandom_range(1, 3));
            else if (r < 84)
                cnt = '0;
            else if (r < 97)
                cnt = CNT_W'($urandom());
            else
                cnt = '1;

            // hold off now and then until every verdict is back
            if ($urandom_range(0, 149) == 0) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_request(mode, rtype, cnt, 1'($urandom_range(0, 1)), now);
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // main sequence
    initial begin
        logic [TIME_W-1:0] q_cd;
        logic [TIME_W-1:0] g_cd;
        logic [TIME_W-1:0] t0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= MODE_CHECK;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_QUERY_COOLDOWN;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        run_live    = 1'b0;
        sb          = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        run_live = 1'b1;

        program_cooldowns(32'd10, 32'd40);
        run_directed();

        for (int p = 0; p < NUM_PHASES; p++) begin
            t0 = 32'd1;
            case (p)
                0: begin
                    q_cd = '0;
                    g_cd = '0;
                end
                1: begin
                    q_cd = $urandom_range(1, 48);
                    g_cd = $urandom_range(1, 48);
                    t0   = 32'hFFFF_FF00;
                end
                2: begin
                    q_cd = '1;
                    g_cd = '1;
                    t0   = $urandom();
                end
                3: begin
                    q_cd = 32'h8000_0000;
                    g_cd = 32'h7FFF_FFFF;
                    t0   = $urandom();
                end
                4: begin
                    q_cd = $urandom_range(1, 48);
                    g_cd = '0;
                end
                5: begin
                    q_cd = 32'd1;
                    g_cd = $urandom_range(1, 48);
                    t0   = $urandom();
                end
                default: begin
                    q_cd = $urandom_range(1, 48);
                    g_cd = $urandom_range(1, 48);
                    t0   = 32'hFFFF_FFF0;
                end
            endcase
            program_cooldowns(q_cd, g_cd);
            run_phase(PHASE_ITEMS, t0);
        end

        repeat (END_SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
